[hdl/bsfb_pkg.sv]
// shared types and constants of the bmp stream to framebuffer blit
package bsfb_pkg;

	localparam int SCREEN_WIDTH   = 800;
	localparam int SCREEN_HEIGHT  = 480;
	localparam int MAX_IMAGE_SIDE = 1024;
	localparam int HEADER_BYTES   = 54;

	// image side counters hold values up to the largest side
	localparam int SIDE_W    = $clog2(MAX_IMAGE_SIDE + 1);
	localparam int HIDX_W    = $clog2(HEADER_BYTES + 1);
	// signed width for screen position sums
	localparam int POS_W     = 15;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int X_W       = 10;
	localparam int Y_W       = 9;
	localparam int COLOR_W   = 24;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = CFG_IDX_W'(1);

	// header byte positions of the little-endian width and height
	localparam logic [HIDX_W-1:0] WIDTH_B0  = HIDX_W'(18);
	localparam logic [HIDX_W-1:0] WIDTH_B3  = HIDX_W'(21);
	localparam logic [HIDX_W-1:0] HEIGHT_B0 = HIDX_W'(22);
	localparam logic [HIDX_W-1:0] HEIGHT_B3 = HIDX_W'(25);
	localparam logic [HIDX_W-1:0] HDR_LAST  = HIDX_W'(HEADER_BYTES - 1);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_PIXELS
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PIXEL      = 2'd0,
		KIND_SIZE_ERR   = 2'd1,
		KIND_OFFSET_ERR = 2'd2
	} kind_t;

	typedef struct packed {
		logic                valid;
		kind_t               kind;
		logic [X_W-1:0]      x;
		logic [Y_W-1:0]      y;
		logic [COLOR_W-1:0]  color;
	} result_t;

endpackage

[hdl/bsfb_parser.sv]
// byte parser: header decode, size and offset checks, pixel assembly
module bsfb_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic [7:0]                      data_byte,
	input  logic                            start_of_file,
	input  logic [bsfb_pkg::CFG_W-1:0]      offset_x,
	input  logic [bsfb_pkg::CFG_W-1:0]      offset_y,
	output bsfb_pkg::result_t               result
);

	localparam int SW = bsfb_pkg::SIDE_W;
	localparam int PW = bsfb_pkg::POS_W;
	localparam int HW = bsfb_pkg::HIDX_W;

	bsfb_pkg::phase_t phase_q, phase_n, phase_e;
	logic [HW-1:0] hidx_q, hidx_n, hidx_e;
	logic [SW-1:0] w_q, w_n, w_e, w_hdr;
	logic [SW-1:0] h_q, h_n, h_e, h_hdr;
	logic          wbig_q, wbig_n, wbig_e, wbig_hdr;
	logic          hbig_q, hbig_n, hbig_e, hbig_hdr;
	logic [SW-1:0] col_q, col_n, col_inc;
	logic [SW-1:0] row_q, row_n, row_inc;
	logic [1:0]    bip_q, bip_n;
	logic [1:0]    pad_q, pad_n;
	logic [7:0]    blue_q, blue_n, green_q, green_n;

	logic          in_w, in_h, hdr_last, size_bad, off_bad;
	logic [1:0]    byte_k;
	logic [31:0]   contrib;
	logic signed [PW-1:0] ox_s, oy_s, wx_sum, hy_sum, sx, sy;
	logic          on_screen, row_end;

	// restart folds into the header parse of the same byte
	assign phase_e = start_of_file ? bsfb_pkg::PH_HEADER : phase_q;
	assign hidx_e  = start_of_file ? '0 : hidx_q;
	assign w_e     = start_of_file ? '0 : w_q;
	assign h_e     = start_of_file ? '0 : h_q;
	assign wbig_e  = start_of_file ? 1'b0 : wbig_q;
	assign hbig_e  = start_of_file ? 1'b0 : hbig_q;

	assign in_w    = (hidx_e >= bsfb_pkg::WIDTH_B0) && (hidx_e <= bsfb_pkg::WIDTH_B3);
	assign in_h    = (hidx_e >= bsfb_pkg::HEIGHT_B0) && (hidx_e <= bsfb_pkg::HEIGHT_B3);
	assign byte_k  = in_w ? 2'(hidx_e - bsfb_pkg::WIDTH_B0) : 2'(hidx_e - bsfb_pkg::HEIGHT_B0);
	assign contrib = 32'(data_byte) << {byte_k, 3'b000};

	// low bits kept exactly, anything above the side range only as a flag
	assign w_hdr    = in_w ? (w_e | contrib[SW-1:0]) : w_e;
	assign wbig_hdr = wbig_e | (in_w && (|contrib[31:SW]));
	assign h_hdr    = in_h ? (h_e | contrib[SW-1:0]) : h_e;
	assign hbig_hdr = hbig_e | (in_h && (|contrib[31:SW]));
	assign hdr_last = (hidx_e == bsfb_pkg::HDR_LAST);

	assign size_bad = wbig_hdr || (w_hdr == '0) || (w_hdr > SW'(bsfb_pkg::MAX_IMAGE_SIDE))
	               || hbig_hdr || (h_hdr == '0) || (h_hdr > SW'(bsfb_pkg::MAX_IMAGE_SIDE));

	assign ox_s   = PW'($signed(offset_x));
	assign oy_s   = PW'($signed(offset_y));
	assign wx_sum = ox_s + $signed(PW'(w_hdr));
	assign hy_sum = oy_s + $signed(PW'(h_hdr));
	assign off_bad = (ox_s > PW'(bsfb_pkg::SCREEN_WIDTH)) || wx_sum[PW-1]
	              || (oy_s > PW'(bsfb_pkg::SCREEN_HEIGHT)) || hy_sum[PW-1];

	// pixel position, rows flipped
	assign sx = ox_s + $signed(PW'(col_q));
	assign sy = oy_s + $signed(PW'(h_q)) - $signed(PW'(row_q)) - $signed(PW'(1));
	assign on_screen = !sx[PW-1] && (sx < PW'(bsfb_pkg::SCREEN_WIDTH))
	                && !sy[PW-1] && (sy < PW'(bsfb_pkg::SCREEN_HEIGHT));

	assign col_inc = col_q + SW'(1);
	assign row_inc = row_q + SW'(1);
	assign row_end = (col_inc >= w_q);

	// next state
	always_comb begin
		phase_n = phase_q;
		hidx_n  = hidx_q;
		w_n     = w_q;
		h_n     = h_q;
		wbig_n  = wbig_q;
		hbig_n  = hbig_q;
		col_n   = col_q;
		row_n   = row_q;
		bip_n   = bip_q;
		pad_n   = pad_q;
		blue_n  = blue_q;
		green_n = green_q;
		if (accept) begin
			case (phase_e)
				bsfb_pkg::PH_HEADER: begin
					phase_n = bsfb_pkg::PH_HEADER;
					hidx_n  = hidx_e + HW'(1);
					w_n     = w_hdr;
					h_n     = h_hdr;
					wbig_n  = wbig_hdr;
					hbig_n  = hbig_hdr;
					if (hdr_last) begin
						if (size_bad || off_bad) begin
							phase_n = bsfb_pkg::PH_IDLE;
						end else begin
							phase_n = bsfb_pkg::PH_PIXELS;
							col_n   = '0;
							row_n   = '0;
							bip_n   = '0;
							pad_n   = '0;
						end
					end
				end
				bsfb_pkg::PH_PIXELS: begin
					if (pad_q != 2'd0) begin
						pad_n = pad_q - 2'd1;
						if (pad_q == 2'd1) begin
							col_n = '0;
							row_n = row_inc;
							if (row_inc >= h_q) phase_n = bsfb_pkg::PH_IDLE;
						end
					end else begin
						case (bip_q)
							2'd0: begin
								blue_n = data_byte;
								bip_n  = 2'd1;
							end
							2'd1: begin
								green_n = data_byte;
								bip_n   = 2'd2;
							end
							2'd2: begin
								bip_n = 2'd0;
								col_n = col_inc;
								if (row_end) begin
									// row padding to a multiple of four bytes is width mod 4
									pad_n = w_q[1:0];
									if (w_q[1:0] == 2'd0) begin
										col_n = '0;
										row_n = row_inc;
										if (row_inc >= h_q) phase_n = bsfb_pkg::PH_IDLE;
									end
								end
							end
							default: begin
								bip_n = 2'd0;
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result of the accepted byte
	always_comb begin
		result = '0;
		if (accept) begin
			case (phase_e)
				bsfb_pkg::PH_HEADER: begin
					if (hdr_last && size_bad) begin
						result.valid = 1'b1;
						result.kind  = bsfb_pkg::KIND_SIZE_ERR;
					end else if (hdr_last && off_bad) begin
						result.valid = 1'b1;
						result.kind  = bsfb_pkg::KIND_OFFSET_ERR;
					end
				end
				bsfb_pkg::PH_PIXELS: begin
					if ((pad_q == 2'd0) && (bip_q == 2'd2) && on_screen) begin
						result.valid = 1'b1;
						result.kind  = bsfb_pkg::KIND_PIXEL;
						result.x     = sx[bsfb_pkg::X_W-1:0];
						result.y     = sy[bsfb_pkg::Y_W-1:0];
						result.color = {data_byte, green_q, blue_q};
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bsfb_pkg::PH_IDLE;
			hidx_q  <= '0;
			w_q     <= '0;
			h_q     <= '0;
			wbig_q  <= 1'b0;
			hbig_q  <= 1'b0;
			col_q   <= '0;
			row_q   <= '0;
			bip_q   <= '0;
			pad_q   <= '0;
			blue_q  <= '0;
			green_q <= '0;
		end else begin
			phase_q <= phase_n;
			hidx_q  <= hidx_n;
			w_q     <= w_n;
			h_q     <= h_n;
			wbig_q  <= wbig_n;
			hbig_q  <= hbig_n;
			col_q   <= col_n;
			row_q   <= row_n;
			bip_q   <= bip_n;
			pad_q   <= pad_n;
			blue_q  <= blue_n;
			green_q <= green_n;
		end
	end

	a_pixels_size_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == bsfb_pkg::PH_PIXELS) |-> (!wbig_q && !hbig_q && (w_q != '0) && (h_q != '0)
			&& (w_q <= SW'(bsfb_pkg::MAX_IMAGE_SIDE)) && (h_q <= SW'(bsfb_pkg::MAX_IMAGE_SIDE))))
		else $error("pixel phase entered with an invalid image size");

	// during row padding the column count sits at the image width
	a_counters_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == bsfb_pkg::PH_PIXELS) |-> (((pad_q != 2'd0) || (col_q < w_q))
			&& (row_q < h_q) && (bip_q != 2'd3)))
		else $error("pixel counters left the image");

	a_padding_at_pixel_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == bsfb_pkg::PH_PIXELS && pad_q != 2'd0) |-> (bip_q == 2'd0 && col_q == w_q))
		else $error("row padding started inside a pixel");

endmodule

[hdl/bmp_stream_to_framebuffer_blit_top.sv]
// top level of the bmp stream to framebuffer blit
// an accepted byte's result item goes into the output register as the byte is taken
// one byte per cycle unless stalled; parser state updates in the same cycle it takes a byte
// input stalls only while a result item is held and the output side stalls
// reset (arst_n low, asynchronous) leaves the parser idle, offsets at zero, no item pending
// no clearing pass: the block takes items from the first cycle after reset
module bmp_stream_to_framebuffer_blit_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// byte input
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        data_byte,
	input  logic                              start_of_file,
	// result output
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        result_kind,
	output logic [bsfb_pkg::X_W-1:0]          screen_x,
	output logic [bsfb_pkg::Y_W-1:0]          screen_y,
	output logic [bsfb_pkg::COLOR_W-1:0]      pixel_color,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [bsfb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bsfb_pkg::CFG_W-1:0]        cfg_data
);

	logic [bsfb_pkg::CFG_W-1:0] offset_x_q, offset_y_q;
	logic                       in_accept;
	logic                       out_load;
	bsfb_pkg::result_t          res;
	bsfb_pkg::result_t          out_q;
	logic                       out_valid_q;

	// offset registers, indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= '0;
			offset_y_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == bsfb_pkg::REG_OFFSET_X) offset_x_q <= cfg_data;
			if (cfg_index == bsfb_pkg::REG_OFFSET_Y) offset_y_q <= cfg_data;
		end
	end

	// the output register frees up in the cycle its item is taken
	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;
	assign out_load  = !out_valid_q || !out_stall;

	bsfb_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (in_accept),
		.data_byte     (data_byte),
		.start_of_file (start_of_file),
		.offset_x      (offset_x_q),
		.offset_y      (offset_y_q),
		.result        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= res.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (out_load && res.valid) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = out_q.kind;
	assign screen_x    = out_q.x;
	assign screen_y    = out_q.y;
	assign pixel_color = out_q.color;

	a_result_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> in_accept)
		else $error("result produced without an accepted byte");

	a_error_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind != bsfb_pkg::KIND_PIXEL) |->
			(out_q.x == '0 && out_q.y == '0 && out_q.color == '0))
		else $error("error item carries a position or colour");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_q)))
		else $error("held result item was overwritten");

endmodule
